// ===== rtl/core/lapy_pkg.sv =====
package lapy_pkg;

   // Output angle scale and internal angle format
   localparam int ANGLE_FRAC_BITS = 12;
   localparam int INT_FRAC        = 24;
   localparam int ROUND_SHIFT     = INT_FRAC - ANGLE_FRAC_BITS;

   // Field and datapath widths
   localparam int COORD_W     = 16;
   localparam int DIFF_W      = COORD_W + 1;
   localparam int SQ_W        = 2 * DIFF_W;
   localparam int COORD_SHIFT = 14;
   localparam int RAD_W       = 62;
   localparam int CRD_W       = 36;
   localparam int ANG_W       = 28;
   localparam int PITCH_W     = 14;
   localparam int YAW_W       = 16;
   localparam int CSR_INDEX_W = 2;

   // Pipeline depth
   localparam int SQRT_STEPS   = 31;
   localparam int CORDIC_STEPS = 24;
   localparam int LATENCY      = SQRT_STEPS + CORDIC_STEPS + 6;

   // Angle constants in Q24 radians; rounding offset and output saturation bounds
   localparam logic signed [ANG_W-1:0] HALF_PI_Q24 = 28'sd26353589;
   localparam logic signed [ANG_W-1:0] PI_Q24      = 28'sd52707179;
   localparam logic signed [ANG_W-1:0] ROUND_HALF  = ANG_W'(2 ** (ROUND_SHIFT - 1));
   localparam logic signed [ANG_W-1:0] PITCH_MAX   = ANG_W'(2 ** (PITCH_W - 1) - 1);
   localparam logic signed [ANG_W-1:0] PITCH_MIN   = ANG_W'(-(2 ** (PITCH_W - 1)));
   localparam logic signed [ANG_W-1:0] YAW_MAX     = ANG_W'(2 ** (YAW_W - 1) - 1);
   localparam logic signed [ANG_W-1:0] YAW_MIN     = ANG_W'(-(2 ** (YAW_W - 1)));

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_POS_X = 2'd0,
      CSR_POS_Y = 2'd1,
      CSR_POS_Z = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic dx_zero;
      logic dx_pos;
      logic dy_zero;
      logic dy_pos;
      logic dz_zero;
      logic dz_pos;
   } dir_flags_type;

   typedef struct packed {
      logic                     valid;
      dir_flags_type            flags;
      logic signed [CRD_W-1:0]  pitch_y;
      logic signed [CRD_W-1:0]  yaw_x;
      logic signed [CRD_W-1:0]  yaw_y;
      logic [RAD_W-1:0]         rem;
      logic [RAD_W-1:0]         root;
   } sqrt_stage_type;

   typedef struct packed {
      logic                     valid;
      dir_flags_type            flags;
      logic                     dist_zero;
      logic signed [CRD_W-1:0]  px;
      logic signed [CRD_W-1:0]  py;
      logic signed [ANG_W-1:0]  pz;
      logic signed [CRD_W-1:0]  yx;
      logic signed [CRD_W-1:0]  yy;
      logic signed [ANG_W-1:0]  yz;
   } cordic_stage_type;

   typedef struct packed {
      logic                     valid;
      logic                     dy_zero;
      logic                     dz_pos;
      logic signed [ANG_W-1:0]  pitch;
      logic signed [ANG_W-1:0]  yaw;
   } finish_stage_type;

   // round(atan(2^-i) * 2^24)
   function automatic logic signed [ANG_W-1:0] atan_entry(input int step);
      logic signed [ANG_W-1:0] value;
      unique case (step)
         0:       value = 28'sd13176795;
         1:       value = 28'sd7778716;
         2:       value = 28'sd4110060;
         3:       value = 28'sd2086331;
         4:       value = 28'sd1047214;
         5:       value = 28'sd524117;
         6:       value = 28'sd262123;
         7:       value = 28'sd131069;
         8:       value = 28'sd65536;
         9:       value = 28'sd32768;
         10:      value = 28'sd16384;
         11:      value = 28'sd8192;
         12:      value = 28'sd4096;
         13:      value = 28'sd2048;
         14:      value = 28'sd1024;
         15:      value = 28'sd512;
         16:      value = 28'sd256;
         17:      value = 28'sd128;
         18:      value = 28'sd64;
         19:      value = 28'sd32;
         20:      value = 28'sd16;
         21:      value = 28'sd8;
         22:      value = 28'sd4;
         23:      value = 28'sd2;
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

// ===== rtl/core/look_at_pitch_yaw_unit.sv =====
// Look-at angle unit. Give a target point with start; busy never rises, so a new target
// may be given in every clock cycle. For each target the unit forms d = position - target
// and pulses rsp_strobe for one cycle with pitch and yaw in signed radians scaled by 4096.
// A target equal to the position gives no strobe at all. The receiver cannot hold results
// off: take them in the strobe cycle.
// The pipeline holds the squaring stages, a 31-stage square root of the horizontal
// distance and 24 CORDIC stages run side by side for pitch and yaw.
// Write the position registers through the csr_ port only while no target is in flight.
module look_at_pitch_yaw_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // target channel
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [lapy_pkg::COORD_W-1:0]  req_target_x,
   input  logic signed [lapy_pkg::COORD_W-1:0]  req_target_y,
   input  logic signed [lapy_pkg::COORD_W-1:0]  req_target_z,
   // result channel
   output logic                                 rsp_strobe,
   output logic signed [lapy_pkg::PITCH_W-1:0]  rsp_pitch_angle,
   output logic signed [lapy_pkg::YAW_W-1:0]    rsp_yaw_angle,
   // register write port
   input  logic                                 csr_wr_en,
   input  logic [lapy_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lapy_pkg::COORD_W-1:0]         csr_wdata
);

   // ---------------------------------------------------------------------------------
   // Position registers
   // ---------------------------------------------------------------------------------
   logic signed [lapy_pkg::COORD_W-1:0] pos_x_ff, pos_x_in;
   logic signed [lapy_pkg::COORD_W-1:0] pos_y_ff, pos_y_in;
   logic signed [lapy_pkg::COORD_W-1:0] pos_z_ff, pos_z_in;

   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      if (csr_wr_en) begin
         unique case (lapy_pkg::csr_index_type'(csr_index))
            lapy_pkg::CSR_POS_X: pos_x_in = csr_wdata;
            lapy_pkg::CSR_POS_Y: pos_y_in = csr_wdata;
            lapy_pkg::CSR_POS_Z: pos_z_in = csr_wdata;
            default: ;   // drop writes beyond the register list
         endcase
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage A: differences; drop the target when it sits on the position
   // ---------------------------------------------------------------------------------
   logic                                 accept;
   logic signed [lapy_pkg::DIFF_W-1:0]   diff_x, diff_y, diff_z;
   logic                                 a_valid_ff, a_valid_in;
   logic signed [lapy_pkg::DIFF_W-1:0]   a_dx_ff, a_dy_ff, a_dz_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign diff_x = lapy_pkg::DIFF_W'(pos_x_ff) - lapy_pkg::DIFF_W'(req_target_x);
   assign diff_y = lapy_pkg::DIFF_W'(pos_y_ff) - lapy_pkg::DIFF_W'(req_target_y);
   assign diff_z = lapy_pkg::DIFF_W'(pos_z_ff) - lapy_pkg::DIFF_W'(req_target_z);

   assign a_valid_in = accept && (diff_x != '0 || diff_y != '0 || diff_z != '0);

   // ---------------------------------------------------------------------------------
   // Stage B: squares of the horizontal components
   // ---------------------------------------------------------------------------------
   logic signed [lapy_pkg::SQ_W-1:0]     prod_x, prod_z;
   logic                                 b_valid_ff;
   logic signed [lapy_pkg::DIFF_W-1:0]   b_dx_ff, b_dy_ff, b_dz_ff;
   logic [lapy_pkg::SQ_W-1:0]            b_sqx_ff, b_sqz_ff, b_sqx_in, b_sqz_in;

   assign prod_x   = a_dx_ff * a_dx_ff;
   assign prod_z   = a_dz_ff * a_dz_ff;
   assign b_sqx_in = $unsigned(prod_x);
   assign b_sqz_in = $unsigned(prod_z);

   // ---------------------------------------------------------------------------------
   // Square root pipeline: entry 0 holds the sum, one result bit per stage after it
   // ---------------------------------------------------------------------------------
   lapy_pkg::sqrt_stage_type sqrt_ff [lapy_pkg::SQRT_STEPS+1];
   lapy_pkg::sqrt_stage_type sqrt_in [lapy_pkg::SQRT_STEPS+1];

   always_comb begin
      logic [lapy_pkg::SQ_W-1:0]           sum;
      logic signed [lapy_pkg::CRD_W-1:0]   dx_ext;
      logic signed [lapy_pkg::CRD_W-1:0]   dz_ext;
      logic [lapy_pkg::RAD_W-1:0]          trial;
      logic [lapy_pkg::RAD_W-1:0]          bit_val;

      sum    = b_sqx_ff + b_sqz_ff;
      dx_ext = lapy_pkg::CRD_W'(b_dx_ff) <<< lapy_pkg::COORD_SHIFT;
      dz_ext = lapy_pkg::CRD_W'(b_dz_ff) <<< lapy_pkg::COORD_SHIFT;

      sqrt_in[0].valid         = b_valid_ff;
      sqrt_in[0].flags.dx_zero = (b_dx_ff == '0);
      sqrt_in[0].flags.dx_pos  = !b_dx_ff[lapy_pkg::DIFF_W-1] && (b_dx_ff != '0);
      sqrt_in[0].flags.dy_zero = (b_dy_ff == '0);
      sqrt_in[0].flags.dy_pos  = !b_dy_ff[lapy_pkg::DIFF_W-1] && (b_dy_ff != '0);
      sqrt_in[0].flags.dz_zero = (b_dz_ff == '0);
      sqrt_in[0].flags.dz_pos  = !b_dz_ff[lapy_pkg::DIFF_W-1] && (b_dz_ff != '0);
      sqrt_in[0].pitch_y       = lapy_pkg::CRD_W'(b_dy_ff) <<< lapy_pkg::COORD_SHIFT;
      // mirror into the right half plane when dz is negative
      if (b_dz_ff[lapy_pkg::DIFF_W-1]) begin
         sqrt_in[0].yaw_x = -dz_ext;
         sqrt_in[0].yaw_y = -dx_ext;
      end else begin
         sqrt_in[0].yaw_x = dz_ext;
         sqrt_in[0].yaw_y = dx_ext;
      end
      sqrt_in[0].rem  = lapy_pkg::RAD_W'(sum) << (2 * lapy_pkg::COORD_SHIFT);
      sqrt_in[0].root = '0;

      for (int k = 0; k < lapy_pkg::SQRT_STEPS; k++) begin
         bit_val      = lapy_pkg::RAD_W'(1) << (2 * (lapy_pkg::SQRT_STEPS - 1 - k));
         trial        = sqrt_ff[k].root + bit_val;
         sqrt_in[k+1] = sqrt_ff[k];
         if (sqrt_ff[k].rem >= trial) begin
            sqrt_in[k+1].rem  = sqrt_ff[k].rem - trial;
            sqrt_in[k+1].root = (sqrt_ff[k].root >> 1) + bit_val;
         end else begin
            sqrt_in[k+1].root = sqrt_ff[k].root >> 1;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // CORDIC pipeline, vectoring mode, pitch and yaw side by side
   // ---------------------------------------------------------------------------------
   lapy_pkg::cordic_stage_type cordic_ff [lapy_pkg::CORDIC_STEPS+1];
   lapy_pkg::cordic_stage_type cordic_in [lapy_pkg::CORDIC_STEPS+1];

   always_comb begin
      logic [lapy_pkg::RAD_W-1:0]          hdist;
      logic signed [lapy_pkg::CRD_W-1:0]   px_s, py_s, yx_s, yy_s;

      hdist = sqrt_ff[lapy_pkg::SQRT_STEPS].root;

      cordic_in[0].valid     = sqrt_ff[lapy_pkg::SQRT_STEPS].valid;
      cordic_in[0].flags     = sqrt_ff[lapy_pkg::SQRT_STEPS].flags;
      cordic_in[0].dist_zero = (hdist == '0);
      cordic_in[0].px        = $signed(lapy_pkg::CRD_W'(hdist));
      cordic_in[0].py        = sqrt_ff[lapy_pkg::SQRT_STEPS].pitch_y;
      cordic_in[0].pz        = '0;
      cordic_in[0].yx        = sqrt_ff[lapy_pkg::SQRT_STEPS].yaw_x;
      cordic_in[0].yy        = sqrt_ff[lapy_pkg::SQRT_STEPS].yaw_y;
      cordic_in[0].yz        = '0;

      for (int i = 0; i < lapy_pkg::CORDIC_STEPS; i++) begin
         px_s           = cordic_ff[i].px >>> i;
         py_s           = cordic_ff[i].py >>> i;
         yx_s           = cordic_ff[i].yx >>> i;
         yy_s           = cordic_ff[i].yy >>> i;
         cordic_in[i+1] = cordic_ff[i];
         // rotate toward the x axis, accumulate the angle turned
         if (!cordic_ff[i].py[lapy_pkg::CRD_W-1]) begin
            cordic_in[i+1].px = cordic_ff[i].px + py_s;
            cordic_in[i+1].py = cordic_ff[i].py - px_s;
            cordic_in[i+1].pz = cordic_ff[i].pz + lapy_pkg::atan_entry(i);
         end else begin
            cordic_in[i+1].px = cordic_ff[i].px - py_s;
            cordic_in[i+1].py = cordic_ff[i].py + px_s;
            cordic_in[i+1].pz = cordic_ff[i].pz - lapy_pkg::atan_entry(i);
         end
         if (!cordic_ff[i].yy[lapy_pkg::CRD_W-1]) begin
            cordic_in[i+1].yx = cordic_ff[i].yx + yy_s;
            cordic_in[i+1].yy = cordic_ff[i].yy - yx_s;
            cordic_in[i+1].yz = cordic_ff[i].yz + lapy_pkg::atan_entry(i);
         end else begin
            cordic_in[i+1].yx = cordic_ff[i].yx - yy_s;
            cordic_in[i+1].yy = cordic_ff[i].yy + yx_s;
            cordic_in[i+1].yz = cordic_ff[i].yz - lapy_pkg::atan_entry(i);
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Finish stage: pick special-case angles, add pi when the target lies behind
   // ---------------------------------------------------------------------------------
   lapy_pkg::cordic_stage_type   last;
   lapy_pkg::finish_stage_type   fin_ff, fin_in;

   assign last = cordic_ff[lapy_pkg::CORDIC_STEPS];

   always_comb begin
      logic signed [lapy_pkg::ANG_W-1:0] yaw_base;

      fin_in.valid   = last.valid;
      fin_in.dy_zero = last.flags.dy_zero;
      fin_in.dz_pos  = last.flags.dz_pos;

      if (last.flags.dy_zero) begin
         fin_in.pitch = '0;
      end else if (last.dist_zero) begin
         fin_in.pitch = last.flags.dy_pos ? lapy_pkg::HALF_PI_Q24 : -lapy_pkg::HALF_PI_Q24;
      end else begin
         fin_in.pitch = last.pz;
      end

      if (last.flags.dx_zero) begin
         yaw_base = '0;
      end else if (last.flags.dz_zero) begin
         yaw_base = last.flags.dx_pos ? lapy_pkg::HALF_PI_Q24 : -lapy_pkg::HALF_PI_Q24;
      end else begin
         yaw_base = last.yz;
      end
      fin_in.yaw = last.flags.dz_pos ? yaw_base + lapy_pkg::PI_Q24 : yaw_base;
   end

   // ---------------------------------------------------------------------------------
   // Output stage: round to the output scale, saturate, register
   // ---------------------------------------------------------------------------------
   logic                                  rsp_strobe_ff;
   logic signed [lapy_pkg::PITCH_W-1:0]   rsp_pitch_ff, rsp_pitch_in;
   logic signed [lapy_pkg::YAW_W-1:0]     rsp_yaw_ff, rsp_yaw_in;

   always_comb begin
      logic signed [lapy_pkg::ANG_W-1:0] pitch_r, yaw_r;

      pitch_r = (fin_ff.pitch + lapy_pkg::ROUND_HALF) >>> lapy_pkg::ROUND_SHIFT;
      yaw_r   = (fin_ff.yaw + lapy_pkg::ROUND_HALF) >>> lapy_pkg::ROUND_SHIFT;

      if (pitch_r > lapy_pkg::PITCH_MAX) begin
         pitch_r = lapy_pkg::PITCH_MAX;
      end else if (pitch_r < lapy_pkg::PITCH_MIN) begin
         pitch_r = lapy_pkg::PITCH_MIN;
      end
      if (yaw_r > lapy_pkg::YAW_MAX) begin
         yaw_r = lapy_pkg::YAW_MAX;
      end else if (yaw_r < lapy_pkg::YAW_MIN) begin
         yaw_r = lapy_pkg::YAW_MIN;
      end

      rsp_pitch_in = lapy_pkg::PITCH_W'(pitch_r);
      rsp_yaw_in   = lapy_pkg::YAW_W'(yaw_r);
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_pitch_angle = rsp_pitch_ff;
   assign rsp_yaw_angle   = rsp_yaw_ff;

   // ---------------------------------------------------------------------------------
   // Registers advance every cycle; reset clears position, valids, sqrt/CORDIC/finish
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      a_dx_ff    <= diff_x;
      a_dy_ff    <= diff_y;
      a_dz_ff    <= diff_z;

      b_dx_ff    <= a_dx_ff;
      b_dy_ff    <= a_dy_ff;
      b_dz_ff    <= a_dz_ff;
      b_sqx_ff   <= b_sqx_in;
      b_sqz_ff   <= b_sqz_in;

      rsp_pitch_ff  <= rsp_pitch_in;
      rsp_yaw_ff    <= rsp_yaw_in;

      if (reset) begin
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         pos_z_ff      <= '0;
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         sqrt_ff       <= '{default: '0};
         cordic_ff     <= '{default: '0};
         fin_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         pos_x_ff      <= pos_x_in;
         pos_y_ff      <= pos_y_in;
         pos_z_ff      <= pos_z_in;
         a_valid_ff    <= a_valid_in;
         b_valid_ff    <= a_valid_ff;
         sqrt_ff       <= sqrt_in;
         cordic_ff     <= cordic_in;
         fin_ff        <= fin_in;
         rsp_strobe_ff <= fin_ff.valid;
      end
   end

   // ---------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------
   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, lapy_pkg::LATENCY))
      else $error("result transfer without a target taken at the fixed latency");

   a_no_zero_item: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff |-> (a_dx_ff != '0 || a_dy_ff != '0 || a_dz_ff != '0))
      else $error("target on the position entered the pipeline");

   a_flat_pitch: assert property (@(posedge clock) disable iff (reset)
      fin_ff.valid && fin_ff.dy_zero |=> rsp_strobe && rsp_pitch_angle == '0)
      else $error("nonzero pitch for zero height difference");

   a_behind_yaw: assert property (@(posedge clock) disable iff (reset)
      fin_ff.valid && fin_ff.dz_pos |=> rsp_strobe && rsp_yaw_angle > 0)
      else $error("yaw not turned by pi for positive dz");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

class angle_scoreboard;
   logic signed [13:0] exp_pitch_q[$];
   logic signed [15:0] exp_yaw_q[$];
   int errors;

   function new();
      errors = 0;
   endfunction

   // Note an accepted target: push its expected angles, if it gives any
   function void note_target(logic [1:0] gives, logic signed [13:0] p, logic signed [15:0] y);
      if (gives[0]) begin
         exp_pitch_q.push_back(p);
         exp_yaw_q.push_back(y);
      end
   endfunction

   function void check_angles(logic signed [13:0] p, logic signed [15:0] y);
      logic signed [13:0] ep;
      logic signed [15:0] ey;
      if (exp_pitch_q.size() == 0) begin
         $error("unexpected result pitch=%0d yaw=%0d", p, y);
         errors++;
         return;
      end
      ep = exp_pitch_q.pop_front();
      ey = exp_yaw_q.pop_front();
      if (p !== ep) begin
         $error("pitch_angle expected %0d actual %0d", ep, p);
         errors++;
      end
      if (y !== ey) begin
         $error("yaw_angle expected %0d actual %0d", ey, y);
         errors++;
      end
   endfunction

   function int pending();
      return exp_pitch_q.size();
   endfunction
endclass

module tb_top;

   localparam longint HALF_PI = 26353589;
   localparam longint PI_VAL  = 52707179;
   localparam int     DRAIN   = lapy_pkg::LATENCY + 20;
   localparam longint CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [15:0] req_target_x = '0, req_target_y = '0, req_target_z = '0;
   logic rsp_strobe;
   logic signed [13:0] rsp_pitch_angle;
   logic signed [15:0] rsp_yaw_angle;
   logic csr_wr_en = 1'b0;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   logic signed [15:0] pos_reg [3];
   int send_idle_pct;
   longint cycle_count = 0;
   angle_scoreboard board;

   look_at_pitch_yaw_unit DUT (.*);

   always #4 clock = ~clock;

   // Timeout watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("look_at_pitch_yaw_unit test failed");
         $finish;
      end
   end

   // Results can't be held off: check each strobe at the edge that ends it
   always @(posedge clock) begin
      if (!reset && rsp_strobe) board.check_angles(rsp_pitch_angle, rsp_yaw_angle);
   end

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint root_floor(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return longint'(res);
   endfunction

   // Vectoring CORDIC: atan(y/x) in Q24 for x > 0
   function automatic longint vector_atan(longint x, longint y);
      longint z, xs, ys;
      z = 0;
      for (int i = 0; i < lapy_pkg::CORDIC_STEPS; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (y >= 0) begin
            x = x + ys; y = y - xs; z += longint'(lapy_pkg::atan_entry(i));
         end else begin
            x = x - ys; y = y + xs; z -= longint'(lapy_pkg::atan_entry(i));
         end
      end
      return z;
   endfunction

   function automatic longint round_sat(longint q24, int w);
      longint v, hi, lo;
      v = floor_shift(q24 + (longint'(1) << (lapy_pkg::ROUND_SHIFT - 1)),
                      lapy_pkg::ROUND_SHIFT);
      hi = (longint'(1) << (w - 1)) - 1;
      lo = -(longint'(1) << (w - 1));
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v;
   endfunction

   // Predict angles for one target; returns 1 when a result is due
   task automatic predict_angles(input logic signed [15:0] tx, ty, tz,
                                 output logic gives, output logic signed [13:0] p,
                                 output logic signed [15:0] y);
      longint dx, dy, dz, pitch, yaw, hdist;
      dx = longint'(pos_reg[0]) - longint'(tx);
      dy = longint'(pos_reg[1]) - longint'(ty);
      dz = longint'(pos_reg[2]) - longint'(tz);
      pitch = 0; yaw = 0;
      gives = !(dx == 0 && dy == 0 && dz == 0);
      if (dy != 0) begin
         hdist = root_floor(longint'(dx * dx + dz * dz) << 28);
         if (hdist == 0) pitch = (dy > 0) ? HALF_PI : -HALF_PI;
         else pitch = vector_atan(hdist, dy * 16384);
      end
      if (dx != 0) begin
         if (dz == 0) yaw = (dx > 0) ? HALF_PI : -HALF_PI;
         else if (dz > 0) yaw = vector_atan(dz * 16384, dx * 16384);
         else yaw = vector_atan(-dz * 16384, -dx * 16384);
      end
      if (dz > 0) yaw += PI_VAL;
      p = 14'(round_sat(pitch, 14));
      y = 16'(round_sat(yaw, 16));
   endtask

   task automatic write_pos(input lapy_pkg::csr_index_type idx, input logic [15:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      pos_reg[idx] = val;
   endtask

   // Drain all expected results, then let the pipe empty
   task automatic wait_idle();
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic set_position(input logic [15:0] x, y, z);
      wait_idle();
      write_pos(lapy_pkg::CSR_POS_X, x);
      write_pos(lapy_pkg::CSR_POS_Y, y);
      write_pos(lapy_pkg::CSR_POS_Z, z);
   endtask

   // Transfer one target; start stays high across back-to-back transfers
   task automatic send_target(input logic signed [15:0] tx, ty, tz);
      logic g;
      logic signed [13:0] p;
      logic signed [15:0] y;
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_target_x <= tx;
      req_target_y <= ty;
      req_target_z <= tz;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_angles(tx, ty, tz, g, p, y);
      board.note_target({1'b0, g}, p, y);
   endtask

   task automatic end_burst();
      start <= 1'b0;
      @(posedge clock);
   endtask

   // Random target: near the position, sharing coordinates with it, on it, or anywhere
   task automatic random_target();
      logic signed [15:0] tx, ty, tz;
      int mode;
      mode = $urandom_range(9);
      tx = 16'($urandom); ty = 16'($urandom); tz = 16'($urandom);
      if (mode < 3) begin
         tx = pos_reg[0] + 16'($urandom_range(8) - 4);
         ty = pos_reg[1] + 16'($urandom_range(8) - 4);
         tz = pos_reg[2] + 16'($urandom_range(8) - 4);
      end else if (mode == 3) begin
         tx = pos_reg[0];
         if ($urandom_range(1)) tz = pos_reg[2];
      end else if (mode == 4) begin
         ty = pos_reg[1];
         if ($urandom_range(1)) tz = pos_reg[2];
      end else if (mode == 5) begin
         tx = pos_reg[0]; ty = pos_reg[1]; tz = pos_reg[2];
      end
      send_target(tx, ty, tz);
   endtask

   initial begin
      board = new();
      pos_reg[0] = '0; pos_reg[1] = '0; pos_reg[2] = '0;
      send_idle_pct = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: target at origin (no result), axis cases, extremes
      send_target(16'sd0, 16'sd0, 16'sd0);
      send_target(16'sd256, 16'sd0, 16'sd0);
      send_target(-16'sd256, 16'sd0, 16'sd0);
      send_target(16'sd0, 16'sd256, 16'sd0);
      send_target(16'sd0, -16'sd256, 16'sd0);
      send_target(16'sd0, 16'sd0, 16'sd256);
      send_target(16'sd0, 16'sd0, -16'sd256);
      send_target(16'sd100, 16'sd50, -16'sd300);
      send_target(-16'sd32768, -16'sd32768, -16'sd32768);
      send_target(16'sd32767, 16'sd32767, 16'sd32767);
      send_target(16'sd1, -16'sd1, 16'sd1);
      end_burst();
      set_position(16'h7FFF, 16'h8000, 16'h7FFF);
      send_target(-16'sd32768, 16'sd32767, -16'sd32768);
      send_target(16'sd32767, -16'sd32768, 16'sd32767);
      send_target(16'sd32767, 16'sd0, -16'sd32768);
      end_burst();
      set_position(16'h8000, 16'h7FFF, 16'h8000);
      send_target(16'sd32767, -16'sd32768, 16'sd32767);
      send_target(-16'sd32768, 16'sd32767, -16'sd32768);
      send_target(16'sd0, 16'sd0, 16'sd0);
      end_burst();

      // Random phases, each with its own position; the idle share changes every two phases
      for (int ph = 0; ph < 6; ph++) begin
         set_position(16'($urandom), 16'($urandom), 16'($urandom));
         send_idle_pct = (ph < 2) ? 37 : (ph < 4) ? 57 : 0;
         for (int n = 0; n < 125; n++) begin
            random_target();
            // Hold off until every expected result has come
            if (n == 60) begin
               end_burst();
               while (board.pending() != 0) @(posedge clock);
            end
         end
         end_burst();
      end

      wait_idle();
      if (board.errors == 0 && board.pending() == 0) begin
         $display("look_at_pitch_yaw_unit test passed");
      end else begin
         $display("look_at_pitch_yaw_unit test failed");
      end
      $finish;
   end
endmodule
